[rtl/core/sdik_pkg.sv]
// ----------------------------------------------------------------------------
// sdik_pkg
// Shared constants, types and the arctangent table for the swerve drive
// inverse kinematics unit.
// ----------------------------------------------------------------------------
package sdik_pkg;

    // defaults for the top level parameters
    localparam int WHEEL_COUNT_DEF   = 4;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_LEN          = 24;

    // field widths
    localparam int VEL_W      = 16;
    localparam int ANG_W      = 32;
    localparam int SPEED_W    = 32;
    localparam int RAD_W      = 24;
    localparam int LEVER_W    = 32;
    localparam int HALF_W     = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // datapath widths
    localparam int VEC_W     = 32;
    localparam int SQ_W      = 64;
    localparam int ROOT_W    = 32;
    localparam int REM_W     = 35;
    localparam int X_W       = 35;
    localparam int PROD_W    = ROOT_W + RAD_W;
    localparam int SPEED_SH  = 26;

    // pipeline layout
    localparam int SQRT_STEPS   = SQ_W / 2;
    localparam int FRONT_STAGES = 3;
    localparam int BACK_STAGES  = 2;
    localparam int LATENCY      = FRONT_STAGES + SQRT_STEPS + BACK_STAGES;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INV_RADIUS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVER_BASE = 4'd1;

    localparam logic [RAD_W-1:0]   IRAD_RESET   = 24'd1310720;
    localparam logic signed [HALF_W-1:0] QUARTER_TURN = 16'sd16384;
    localparam logic [ANG_W-1:0]   HALF_TURN32  = 32'h8000_0000;
    localparam logic [HALF_W-1:0]  HALF_TURN16  = 16'h8000;

    // one cell's worth of payload: root extraction and vectoring rotation
    typedef struct packed {
        logic [SQ_W-1:0]         rad;
        logic [REM_W-1:0]        rem;
        logic [ROOT_W-1:0]       root;
        logic signed [X_W-1:0]   x;
        logic signed [X_W-1:0]   y;
        logic [ANG_W-1:0]        z;
        logic                    zero;
        logic [ANG_W-1:0]        now;
    } sdik_cell_t;

    // arctangent of 2^-i, 2^32 units per turn
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] a;
        case (idx)
            0:  a = 32'h20000000;
            1:  a = 32'h12E4051E;
            2:  a = 32'h09FB385B;
            3:  a = 32'h051111D4;
            4:  a = 32'h028B0D43;
            5:  a = 32'h0145D7E1;
            6:  a = 32'h00A2F61E;
            7:  a = 32'h00517C55;
            8:  a = 32'h0028BE53;
            9:  a = 32'h00145F2F;
            10: a = 32'h000A2F98;
            11: a = 32'h000517CC;
            12: a = 32'h00028BE6;
            13: a = 32'h000145F3;
            14: a = 32'h0000A2FA;
            15: a = 32'h0000517D;
            16: a = 32'h000028BE;
            17: a = 32'h0000145F;
            18: a = 32'h00000A30;
            19: a = 32'h00000518;
            20: a = 32'h0000028C;
            21: a = 32'h00000146;
            22: a = 32'h000000A3;
            23: a = 32'h00000051;
            default: a = 32'h0;
        endcase
        return a;
    endfunction

endpackage

[rtl/core/swerve_drive_inverse_kinematics_unit.sv]
// ----------------------------------------------------------------------------
// swerve_drive_inverse_kinematics_unit
// Wheel speed and steer heading for every wheel of a swerve chassis from a
// velocity command, with nearest transposition of the current angle.
// ----------------------------------------------------------------------------
// stages: 37 register stages (3 front stages, 32 root and rotation cells,
//   multiply, output)
// throughput: one item per cycle; each stage stalls only when the stage after
//   it is full, so bubbles close up while a result waits to be taken
// reset: clears the stage valid bits, inverse radius to 1310720, levers to 0
// ----------------------------------------------------------------------------
module swerve_drive_inverse_kinematics_unit
    import sdik_pkg::*;
#(
    parameter int WHEEL_COUNT   = WHEEL_COUNT_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // vx, vy, yaw rate, then steer_now per wheel
    input  logic [3*VEL_W+WHEEL_COUNT*ANG_W-1:0] s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // speed per wheel, then heading per wheel
    output logic [WHEEL_COUNT*(SPEED_W+ANG_W)-1:0] m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [CFG_IDX_W-1:0]              cfg_index,
    input  logic [CFG_DATA_W-1:0]             cfg_data
);

    localparam int IN_BASE  = 3 * VEL_W;
    localparam int HDG_BASE = WHEEL_COUNT * SPEED_W;

    logic [RAD_W-1:0]   irad_reg;
    logic [LEVER_W-1:0] lever_reg [WHEEL_COUNT];
    logic [LATENCY-1:0] valid_reg;
    logic [LATENCY-1:0] en;

    // configuration writes, taken only while the row is empty
    assign cfg_ready = aresetn && (valid_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            irad_reg <= IRAD_RESET;
            for (int j = 0; j < WHEEL_COUNT; j++) begin
                lever_reg[j] <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_INV_RADIUS) begin
                irad_reg <= cfg_data[RAD_W-1:0];
            end
            for (int j = 0; j < WHEEL_COUNT; j++) begin
                if (cfg_index == REG_LEVER_BASE + CFG_IDX_W'(j)) begin
                    lever_reg[j] <= cfg_data;
                end
            end
        end
    end

    // per stage advance: a stage loads when empty or its successor moves
    always_comb begin
        en[LATENCY-1] = !valid_reg[LATENCY-1] || m_tready;
        for (int k = LATENCY - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < LATENCY; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign s_tready = en[0] && aresetn;
    assign m_tvalid = valid_reg[LATENCY-1];

    // one lane per wheel
    for (genvar j = 0; j < WHEEL_COUNT; j++) begin : g_lane
        sdik_lane #(
            .CORDIC_STAGES (CORDIC_STAGES)
        ) u_lane (
            .aclk       (aclk),
            .en         (en),
            .vx         (signed'(s_tdata[VEL_W-1:0])),
            .vy         (signed'(s_tdata[2*VEL_W-1 -: VEL_W])),
            .yaw        (signed'(s_tdata[3*VEL_W-1 -: VEL_W])),
            .steer_now  (s_tdata[IN_BASE+j*ANG_W +: ANG_W]),
            .lever      (lever_reg[j]),
            .inv_radius (irad_reg),
            .speed      (m_tdata[j*SPEED_W +: SPEED_W]),
            .heading    (m_tdata[HDG_BASE+j*ANG_W +: ANG_W])
        );
    end

    // an empty output stage lets the whole row move
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    // an accepted item lands in the first stage
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> valid_reg[0])
        else $error("accepted item lost at first stage");

    // a finished item moves into an empty output stage
    a_output_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[LATENCY-2] && !m_tvalid |=> m_tvalid)
        else $error("result did not reach output stage");

    // a result taken while the next one is ready keeps the output full
    a_stream_flows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && valid_reg[LATENCY-2] |=> m_tvalid)
        else $error("bubble inserted between back to back results");

endmodule

[rtl/core/sdik_cell.sv]
// ----------------------------------------------------------------------------
// sdik_cell
// One cell of the chain: one bit of the integer square root and, in the
// first cells, one vectoring rotation of the arctangent.
// ----------------------------------------------------------------------------
module sdik_cell
    import sdik_pkg::*;
#(
    parameter int STEP          = 0,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic       aclk,
    input  logic       en,
    input  sdik_cell_t cell_in,
    output sdik_cell_t cell_out
);

    localparam logic [5:0]  SH     = 6'(STEP);
    localparam logic [31:0] ATAN_C = atan_turn(STEP);
    localparam bit          ROTATE = (STEP < CORDIC_STAGES) && (STEP < ATAN_LEN);

    logic [REM_W-1:0]      rem_sh;
    logic [REM_W-1:0]      trial;
    logic signed [X_W-1:0] dx;
    logic signed [X_W-1:0] dy;
    sdik_cell_t            cell_next;

    // restoring root bit and rotation step
    always_comb begin
        rem_sh    = {cell_in.rem[REM_W-3:0], cell_in.rad[SQ_W-1 -: 2]};
        trial     = {1'b0, cell_in.root, 2'b01};
        dx        = cell_in.y >>> SH;
        dy        = cell_in.x >>> SH;
        cell_next = cell_in;
        cell_next.rad = {cell_in.rad[SQ_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            cell_next.rem  = rem_sh - trial;
            cell_next.root = {cell_in.root[ROOT_W-2:0], 1'b1};
        end else begin
            cell_next.rem  = rem_sh;
            cell_next.root = {cell_in.root[ROOT_W-2:0], 1'b0};
        end
        if (ROTATE) begin
            if (cell_in.y[X_W-1]) begin
                cell_next.x = cell_in.x - dx;
                cell_next.y = cell_in.y + dy;
                cell_next.z = cell_in.z - ATAN_C;
            end else begin
                cell_next.x = cell_in.x + dx;
                cell_next.y = cell_in.y - dy;
                cell_next.z = cell_in.z + ATAN_C;
            end
        end
    end

    // hand on to the neighbour
    always_ff @(posedge aclk) begin
        if (en) begin
            cell_out <= cell_next;
        end
    end

endmodule

[rtl/core/sdik_lane.sv]
// ----------------------------------------------------------------------------
// sdik_lane
// Datapath of one wheel: wheel velocity, squares, the chain of root and
// rotation cells, speed scaling and nearest transposition.
// ----------------------------------------------------------------------------
module sdik_lane
    import sdik_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                     aclk,
    input  logic [LATENCY-1:0]       en,
    input  logic signed [VEL_W-1:0]  vx,
    input  logic signed [VEL_W-1:0]  vy,
    input  logic signed [VEL_W-1:0]  yaw,
    input  logic [ANG_W-1:0]         steer_now,
    input  logic [LEVER_W-1:0]       lever,
    input  logic [RAD_W-1:0]         inv_radius,
    output logic [SPEED_W-1:0]       speed,
    output logic [ANG_W-1:0]         heading
);

    localparam int ST_SQ   = 1;
    localparam int ST_SUM  = 2;
    localparam int ST_MUL  = FRONT_STAGES + SQRT_STEPS;
    localparam int ST_OUT  = ST_MUL + 1;

    logic signed [VEL_W-1:0] lx;
    logic signed [VEL_W-1:0] ly;
    logic signed [VEC_W-1:0] wly;
    logic signed [VEC_W-1:0] wlx;
    logic signed [VEC_W-1:0] tx_next, ty_next, tx_reg, ty_reg;
    logic [ANG_W-1:0]        now0_reg;
    logic [VEC_W-1:0]        ax, ay;
    logic [SQ_W-1:0]         ax2_reg, ay2_reg;
    sdik_cell_t              pre_next, pre_reg;
    sdik_cell_t              head_next;
    sdik_cell_t              chain [SQRT_STEPS+1];
    sdik_cell_t              last;
    logic [PROD_W-1:0]       prod;
    logic [SPEED_W-1:0]      mspeed_next, mspeed_reg;
    logic [HALF_W-1:0]       target;
    logic [HALF_W-1:0]       d16_next, d16_reg;
    logic [ANG_W-1:0]        now_m_reg;
    logic [HALF_W-1:0]       f16;
    logic signed [HALF_W-1:0] dsig;
    logic [SPEED_W-1:0]      speed_next, speed_reg;
    logic [ANG_W-1:0]        heading_next, heading_reg;

    // wheel velocity from chassis command and lever
    always_comb begin
        lx      = signed'(lever[LEVER_W-1 -: VEL_W]);
        ly      = signed'(lever[VEL_W-1:0]);
        wly     = yaw * ly;
        wlx     = yaw * lx;
        tx_next = {{2{vx[VEL_W-1]}}, vx, 14'b0} - wly;
        ty_next = {{2{vy[VEL_W-1]}}, vy, 14'b0} + wlx;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            tx_reg   <= tx_next;
            ty_reg   <= ty_next;
            now0_reg <= steer_now;
        end
    end

    // squares and half-turn prerotation
    always_comb begin
        ax = tx_reg[VEC_W-1] ? VEC_W'(-tx_reg) : VEC_W'(tx_reg);
        ay = ty_reg[VEC_W-1] ? VEC_W'(-ty_reg) : VEC_W'(ty_reg);
        pre_next      = '0;
        pre_next.now  = now0_reg;
        pre_next.zero = (tx_reg == '0) && (ty_reg == '0);
        if (tx_reg[VEC_W-1]) begin
            pre_next.x = -X_W'(tx_reg);
            pre_next.y = -X_W'(ty_reg);
            pre_next.z = HALF_TURN32;
        end else begin
            pre_next.x = X_W'(tx_reg);
            pre_next.y = X_W'(ty_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_SQ]) begin
            ax2_reg <= SQ_W'(ax) * SQ_W'(ax);
            ay2_reg <= SQ_W'(ay) * SQ_W'(ay);
            pre_reg <= pre_next;
        end
    end

    // radicand into the first cell
    always_comb begin
        head_next     = pre_reg;
        head_next.rad = ax2_reg + ay2_reg;
    end

    always_ff @(posedge aclk) begin
        if (en[ST_SUM]) begin
            chain[0] <= head_next;
        end
    end

    // chain of cells
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_cell
        sdik_cell #(
            .STEP          (k),
            .CORDIC_STAGES (CORDIC_STAGES)
        ) u_cell (
            .aclk     (aclk),
            .en       (en[FRONT_STAGES+k]),
            .cell_in  (chain[k]),
            .cell_out (chain[k+1])
        );
    end

    // speed scaling and turn delta
    always_comb begin
        last        = chain[SQRT_STEPS];
        prod        = PROD_W'(last.root) * PROD_W'(inv_radius);
        mspeed_next = SPEED_W'((prod + (PROD_W'(1) << (SPEED_SH - 1))) >> SPEED_SH);
        if (last.zero) begin
            target = last.now[HALF_W-1:0];
        end else begin
            target = last.z[ANG_W-1 -: HALF_W] + HALF_W'(last.z[HALF_W-1]);
        end
        d16_next = target - last.now[HALF_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en[ST_MUL]) begin
            mspeed_reg <= mspeed_next;
            d16_reg    <= d16_next;
            now_m_reg  <= last.now;
        end
    end

    // nearest transposition
    always_comb begin
        dsig = signed'(d16_reg);
        f16  = d16_reg + HALF_TURN16;
        if (dsig >= -QUARTER_TURN && dsig <= QUARTER_TURN) begin
            heading_next = now_m_reg + {{HALF_W{d16_reg[HALF_W-1]}}, d16_reg};
            speed_next   = mspeed_reg;
        end else begin
            heading_next = now_m_reg + {{HALF_W{f16[HALF_W-1]}}, f16};
            speed_next   = -mspeed_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_OUT]) begin
            speed_reg   <= speed_next;
            heading_reg <= heading_next;
        end
    end

    assign speed   = speed_reg;
    assign heading = heading_reg;

endmodule
